@@ hw/rtl/owbm_pkg.sv @@
package owbm_pkg;

    // command codes of a request
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_BIT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_RESET_LOW      = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [2:0] REG_SLOT_START     = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD     = 3'd4;
    localparam logic [2:0] REG_SLOT_RECOVERY  = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE    = 3'd6;
    localparam logic [2:0] REG_READ_TAIL      = 3'd7;

    localparam int CFG_DATA_W = 10;

    // decoupling queues
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } request_t;

    typedef struct packed {
        logic       drive_low;
        logic       drive_high;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } result_t;

    // classified tick as it sits between front end and engine
    typedef struct packed {
        logic       start;
        logic [2:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } item_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_sample_time;
        logic [9:0] reset_tail_time;
        logic [7:0] slot_start_time;
        logic [7:0] write_hold_time;
        logic [7:0] slot_recovery_time;
        logic [7:0] read_sample_time;
        logic [7:0] read_tail_time;
    } cfg_t;

endpackage

@@ hw/rtl/one_wire_bus_master.sv @@
// 1-Wire bus master clocked by one-microsecond ticks. Every transfer on the
// request side is one tick of bus time: it carries the sampled line level and,
// when no command is running, an optional command (reset with presence detect,
// write byte, read byte, read single bit; codes 5..7 and commands given while
// busy act as plain ticks). Every tick yields exactly one result transfer with
// the line drive for that tick, busy/done flags, the latest presence sample
// and, on the done tick of a read, the received data (LSB first). A request
// goes through a two-entry queue to the timing engine, which retires one tick
// per clock into a two-entry result queue whenever that queue has room, so the
// block sustains one transfer per clock on both sides while results are
// popped. Slot and reset timings come from eight config registers
// written through cfg_we/cfg_index/cfg_data; write them only while idle.
module one_wire_bus_master #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  owbm_pkg::request_t                  request,
    output logic                                empty,
    input  logic                                pop,
    output owbm_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import owbm_pkg::*;

    cfg_t     cfg_reg;
    logic     item_valid;
    item_t    item;
    logic     take;
    logic     res_ready;
    result_t  res;

    // config register file, reset to the standard-speed timings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= 10'd480;
            cfg_reg.presence_sample_time <= 10'd100;
            cfg_reg.reset_tail_time      <= 10'd380;
            cfg_reg.slot_start_time      <= 8'd2;
            cfg_reg.write_hold_time      <= 8'd58;
            cfg_reg.slot_recovery_time   <= 8'd1;
            cfg_reg.read_sample_time     <= 8'd10;
            cfg_reg.read_tail_time       <= 8'd49;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RESET_LOW:     cfg_reg.reset_low_time       <= cfg_data;
                REG_PRESENCE_WAIT: cfg_reg.presence_sample_time <= cfg_data;
                REG_RESET_TAIL:    cfg_reg.reset_tail_time      <= cfg_data;
                REG_SLOT_START:    cfg_reg.slot_start_time      <= cfg_data[7:0];
                REG_WRITE_HOLD:    cfg_reg.write_hold_time      <= cfg_data[7:0];
                REG_SLOT_RECOVERY: cfg_reg.slot_recovery_time   <= cfg_data[7:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_time     <= cfg_data[7:0];
                REG_READ_TAIL:     cfg_reg.read_tail_time       <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end: classify the tick and queue it
    owbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // timing engine: one tick per clock whenever a tick is queued and the result queue has room
    owbm_engine #(
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_ready  (res_ready),
        .res        (res)
    );

    // result queue toward the consumer
    owbm_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (res),
        .ready   (res_ready),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ hw/rtl/owbm_front.sv @@
module owbm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  owbm_pkg::request_t request,
    output logic              item_valid,
    output owbm_pkg::item_t   item,
    input  logic              take
);
    import owbm_pkg::*;

    item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    item_t              classified;
    logic               wr_en;

    // commands 5..7 behave as plain ticks
    always_comb
    begin
        classified.start      = request.command inside {[CMD_RESET:CMD_BIT]};
        classified.command    = request.command;
        classified.write_data = request.write_data;
        classified.line_level = request.line_level;
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_en      = push && !full;
    assign item_valid = (count_reg != '0);
    assign item       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + QPTR_W'(1);
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + QPTR_W'(1);
            end
            case ({wr_en, take})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/owbm_engine.sv @@
module owbm_engine #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  owbm_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  owbm_pkg::item_t   item,
    output logic              take,
    input  logic              res_ready,
    output owbm_pkg::result_t res
);
    import owbm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_W_START,
        PH_W_HOLD,
        PH_W_REC,
        PH_R_START,
        PH_R_WAIT,
        PH_R_TAIL
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [9:0]  timer_reg,   timer_next;
    logic [3:0]  count_reg,   count_next;
    logic [7:0]  shift_reg,   shift_next;
    logic        pres_reg,    pres_next;
    logic [2:0]  pend_reg,    pend_next;

    phase_t      ph;
    logic [9:0]  len;
    logic        last;
    logic        slot_end;

    assign take = item_valid && res_ready;

    always_comb
    begin
        ph         = phase_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        slot_end   = 1'b0;
        len        = 10'd1;
        last       = 1'b0;
        res        = '0;

        // command start: this tick is already the first tick of the first phase
        if (phase_reg == PH_IDLE && item.start)
        begin
            pend_next  = item.command;
            count_next = '0;
            timer_next = '0;
            shift_next = (item.command == CMD_WRITE) ? item.write_data : 8'd0;
            case (item.command)
                CMD_RESET: ph = PH_RST_LOW;
                CMD_WRITE: ph = PH_W_START;
                default:   ph = PH_R_START;
            endcase
        end
        phase_next = ph;

        case (ph)
            PH_RST_LOW:  len = (cfg.reset_low_time == '0) ? 10'd1 : cfg.reset_low_time;
            PH_RST_WAIT: len = (cfg.presence_sample_time == '0) ? 10'd1
                                                               : cfg.presence_sample_time;
            PH_RST_TAIL: len = cfg.reset_tail_time;
            PH_W_START,
            PH_R_START:  len = (cfg.slot_start_time == '0) ? 10'd1
                                                            : {2'b00, cfg.slot_start_time};
            PH_W_HOLD:   len = (cfg.write_hold_time == '0) ? 10'd1
                                                            : {2'b00, cfg.write_hold_time};
            PH_W_REC:    len = {2'b00, cfg.slot_recovery_time};
            PH_R_WAIT:   len = (cfg.read_sample_time == '0) ? 10'd1
                                                             : {2'b00, cfg.read_sample_time};
            PH_R_TAIL:   len = {2'b00, cfg.read_tail_time};
            default:     len = 10'd1;
        endcase

        if (ph != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            case (ph)
                PH_RST_LOW,
                PH_W_START,
                PH_R_START: res.drive_low = 1'b1;
                PH_W_HOLD:
                begin
                    res.drive_high = shift_next[0];
                    res.drive_low  = !shift_next[0];
                end
                default: ;
            endcase

            last = ({1'b0, timer_next} + 11'd1) >= {1'b0, len};

            if (last)
            begin
                if (ph == PH_RST_WAIT)
                begin
                    pres_next = !item.line_level;
                end
                else if (ph == PH_R_WAIT)
                begin
                    if (pend_next == CMD_BIT)
                    begin
                        shift_next = {7'd0, item.line_level};
                    end
                    else
                    begin
                        shift_next = {item.line_level, shift_next[7:1]};
                    end
                end

                timer_next = '0;
                // zero-length tail or recovery phases are skipped here
                case (ph)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: phase_next = (cfg.reset_tail_time == '0) ? PH_IDLE
                                                                          : PH_RST_TAIL;
                    PH_W_START:  phase_next = PH_W_HOLD;
                    PH_W_HOLD:
                    begin
                        phase_next = PH_W_REC;
                        slot_end   = (cfg.slot_recovery_time == '0);
                    end
                    PH_W_REC:    slot_end = 1'b1;
                    PH_R_START:  phase_next = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        phase_next = PH_R_TAIL;
                        slot_end   = (cfg.read_tail_time == '0);
                    end
                    PH_R_TAIL:   slot_end = 1'b1;
                    default:     phase_next = PH_IDLE;
                endcase

                if (slot_end)
                begin
                    count_next = count_next + 4'd1;
                    if (pend_next == CMD_WRITE)
                    begin
                        shift_next = {1'b0, shift_next[7:1]};
                    end
                    if (pend_next == CMD_BIT || pend_next == CMD_RESET ||
                        count_next >= 4'(BITS_PER_BYTE))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = (pend_next == CMD_WRITE) ? PH_W_START : PH_R_START;
                    end
                end

                if (phase_next == PH_IDLE)
                begin
                    res.done_res = 1'b1;
                    if (pend_next == CMD_READ || pend_next == CMD_BIT)
                    begin
                        res.read_data = shift_next;
                    end
                end
            end
            else
            begin
                timer_next = timer_next + 10'd1;
            end
        end

        res.presence = pres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            pend_reg  <= CMD_TICK;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

@@ hw/rtl/owbm_resq.sv @@
module owbm_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  owbm_pkg::result_t wr_data,
    output logic              ready,
    output logic              empty,
    input  logic              pop,
    output owbm_pkg::result_t result
);
    import owbm_pkg::*;

    result_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               rd_en;

    assign ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_en  = pop && !empty;
    assign result = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + QPTR_W'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/owbm_checker.sv @@
module owbm_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  logic              pop,
    input  owbm_pkg::result_t result
);
    import owbm_pkg::*;

    // a finishing tick is always a busy tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!result.done_res || result.busy_res))
        else $error("done without busy");

    // never drive both ways at once
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.drive_low && result.drive_high))
        else $error("line driven high and low");

    // read data only shows on a done tick
    a_rdata_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.done_res) |-> (result.read_data == 8'd0))
        else $error("read data outside done tick");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind one_wire_bus_master owbm_checker u_checker (.*);
